[hdl/dotted_ipv4_address_parser_macros.svh]
// assertion macros for the dotted ipv4 address parser
`ifndef DOTTED_IPV4_ADDRESS_PARSER_MACROS_SVH
`define DOTTED_IPV4_ADDRESS_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off while rst_n is low
`define IPV4P_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define IPV4P_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define IPV4P_ASSERT_IMPLY(lbl, ante, cons)

`define IPV4P_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hdl/ipv4p_pkg.sv]
// shared types and constants for the dotted ipv4 address parser
`timescale 1ns / 1ps

package ipv4p_pkg;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // limits on part values
  localparam logic [31:0] PART_MAX      = 32'h0000_00FF;
  localparam logic [31:0] LAST_MAX_TWO  = 32'h00FF_FFFF;
  localparam logic [31:0] LAST_MAX_THREE = 32'h0000_FFFF;
  localparam logic [31:0] LAST_MAX_FOUR = 32'h0000_00FF;
  localparam logic [31:0] ADDR_FAIL     = 32'hFFFF_FFFF;

  // number of parts that can precede a dot
  localparam int unsigned EARLY_PARTS = 3;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_ZERO   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    RDX_DEC = 2'd0,
    RDX_OCT = 2'd1,
    RDX_HEX = 2'd2
  } radix_t;

  // decoded view of one character
  typedef struct packed {
    logic       is_nul;
    logic       is_num;
    logic       is_hex_letter;
    logic       is_zero;
    logic       is_x;
    logic       is_dot;
    logic       is_blank;
    logic [3:0] digit;
  } char_class_t;

  // finished string outcome
  typedef struct packed {
    logic        ok;
    logic [31:0] address;
  } parse_result_t;

endpackage

[hdl/ipv4p_char_class.sv]
// character decoder: digit value and character kind
`timescale 1ns / 1ps

module ipv4p_char_class
  import ipv4p_pkg::*;
(
  input  logic [7:0]  char_code,
  output char_class_t cls
);

  logic is_lc;
  logic is_uc;

  // letter ranges for hex digits
  assign is_lc = (char_code >= CH_LC_A) && (char_code <= CH_LC_F);
  assign is_uc = (char_code >= CH_UC_A) && (char_code <= CH_UC_F);

  // kind flags
  assign cls.is_nul        = (char_code == CH_NUL);
  assign cls.is_num        = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign cls.is_hex_letter = is_lc || is_uc;
  assign cls.is_zero       = (char_code == CH_ZERO);
  assign cls.is_x          = (char_code == CH_LC_X) || (char_code == CH_UC_X);
  assign cls.is_dot        = (char_code == CH_DOT);
  assign cls.is_blank      = (char_code == CH_SPACE) ||
                             ((char_code >= CH_TAB) && (char_code <= CH_CR));

  // digit value: low nibble for 0-9, low nibble plus nine for a-f and A-F
  assign cls.digit = cls.is_num ? char_code[3:0] : (char_code[3:0] + 4'd9);

endmodule

[hdl/ipv4p_step.sv]
// parse state registers and per-character update, with end-of-string result
`timescale 1ns / 1ps

module ipv4p_step
  import ipv4p_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  char_class_t   cls,
  output parse_result_t result
);

  phase_t      phase_r, phase_nxt;
  radix_t      radix_r, radix_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  parts_r [EARLY_PARTS];
  logic [7:0]  parts_nxt [EARLY_PARTS];
  logic [1:0]  count_r, count_nxt;
  logic        failed_r, failed_nxt;
  logic        stopped_r, stopped_nxt;

  logic [31:0] base_acc;
  radix_t      base_rdx;
  logic        take;
  logic [31:0] scaled;
  logic        fits;

  // end-of-string result from the current state
  always_comb begin
    fits = 1'b1;
    result.address = acc_r;
    case (count_r)
      2'd0: begin
        result.address = acc_r;
      end
      2'd1: begin
        fits = (acc_r <= LAST_MAX_TWO);
        result.address = {parts_r[0], acc_r[23:0]};
      end
      2'd2: begin
        fits = (acc_r <= LAST_MAX_THREE);
        result.address = {parts_r[0], parts_r[1], acc_r[15:0]};
      end
      2'd3: begin
        fits = (acc_r <= LAST_MAX_FOUR);
        result.address = {parts_r[0], parts_r[1], parts_r[2], acc_r[7:0]};
      end
      default: begin
        fits = 1'b0;
      end
    endcase
    result.ok = !failed_r && fits;
    if (!result.ok) begin
      result.address = ADDR_FAIL;
    end
  end

  // accumulator times radix, shifts and one add
  always_comb begin
    case (base_rdx)
      RDX_HEX: scaled = {base_acc[27:0], 4'd0};
      RDX_OCT: scaled = {base_acc[28:0], 3'd0};
      default: scaled = {base_acc[28:0], 3'd0} + {base_acc[30:0], 1'b0};
    endcase
  end

  // next state for one character
  always_comb begin
    phase_nxt   = phase_r;
    radix_nxt   = radix_r;
    acc_nxt     = acc_r;
    count_nxt   = count_r;
    failed_nxt  = failed_r;
    stopped_nxt = stopped_r;
    for (int i = 0; i < EARLY_PARTS; i++) begin
      parts_nxt[i] = parts_r[i];
    end
    base_acc = acc_r;
    base_rdx = radix_r;
    take     = 1'b0;

    if (go && cls.is_nul) begin
      // string done: back to the start state
      phase_nxt   = PH_START;
      radix_nxt   = RDX_DEC;
      acc_nxt     = '0;
      count_nxt   = '0;
      failed_nxt  = 1'b0;
      stopped_nxt = 1'b0;
      for (int i = 0; i < EARLY_PARTS; i++) begin
        parts_nxt[i] = '0;
      end
    end else if (go && !failed_r && !stopped_r) begin
      take = 1'b1;
      case (phase_r)
        PH_START: begin
          base_acc  = '0;
          base_rdx  = RDX_DEC;
          acc_nxt   = '0;
          radix_nxt = RDX_DEC;
          if (cls.is_zero) begin
            phase_nxt = PH_ZERO;
            take      = 1'b0;
          end else begin
            phase_nxt = PH_DIGITS;
          end
        end
        PH_ZERO: begin
          phase_nxt = PH_DIGITS;
          if (cls.is_x) begin
            radix_nxt = RDX_HEX;
            take      = 1'b0;
          end else begin
            radix_nxt = RDX_OCT;
            base_rdx  = RDX_OCT;
          end
        end
        default: begin
          phase_nxt = PH_DIGITS;
        end
      endcase

      if (take) begin
        if (cls.is_num || (cls.is_hex_letter && (base_rdx == RDX_HEX))) begin
          acc_nxt = scaled + {28'd0, cls.digit};
        end else if (cls.is_dot) begin
          // close one earlier part
          if ((count_r == 2'd3) || (base_acc > PART_MAX)) begin
            failed_nxt = 1'b1;
          end else begin
            for (int i = 0; i < EARLY_PARTS; i++) begin
              if (count_r == i[1:0]) begin
                parts_nxt[i] = base_acc[7:0];
              end
            end
            count_nxt = count_r + 2'd1;
            acc_nxt   = '0;
            radix_nxt = RDX_DEC;
            phase_nxt = PH_START;
          end
        end else if (cls.is_blank) begin
          stopped_nxt = 1'b1;
        end else begin
          failed_nxt = 1'b1;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      radix_r   <= RDX_DEC;
      acc_r     <= '0;
      count_r   <= '0;
      failed_r  <= 1'b0;
      stopped_r <= 1'b0;
      for (int i = 0; i < EARLY_PARTS; i++) begin
        parts_r[i] <= '0;
      end
    end else begin
      phase_r   <= phase_nxt;
      radix_r   <= radix_nxt;
      acc_r     <= acc_nxt;
      count_r   <= count_nxt;
      failed_r  <= failed_nxt;
      stopped_r <= stopped_nxt;
      for (int i = 0; i < EARLY_PARTS; i++) begin
        parts_r[i] <= parts_nxt[i];
      end
    end
  end

endmodule

[hdl/dotted_ipv4_address_parser.sv]
// top level: input register, parse step and result register
`timescale 1ns / 1ps
`include "dotted_ipv4_address_parser_macros.svh"

// Dotted IPv4 address parser. Feed the address text one byte per transfer,
// closed by a NUL byte; only the NUL yields a result (ok and the 32-bit
// address, first part in the top byte, all ones on failure), after which the
// parser is ready for the next string. Parts may be decimal, octal after a
// leading 0, or hex after 0x/0X; whitespace ends the parse. One character is
// taken every clock cycle while in_stall is low: the parse state is updated by a
// single shift-add step per cycle between the input register and the state
// registers, and a NUL's result is then registered in the result register.
// When the result register is full and stalled, a waiting NUL holds the input
// register and in_stall rises; other characters keep flowing.
module dotted_ipv4_address_parser
  import ipv4p_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [31:0] out_address
);

  logic          char_valid_r;
  logic [7:0]    char_r;
  char_class_t   cls;
  parse_result_t result;
  logic          step_go;
  logic          step_fire;
  logic          out_valid_r;
  logic          out_ok_r;
  logic [31:0]   out_address_r;

  // decode the held character
  ipv4p_char_class u_class (
    .char_code (char_r),
    .cls       (cls)
  );

  // a NUL may only move on when the result register can take it
  assign step_go   = !(cls.is_nul && out_valid_r && out_stall);
  assign step_fire = char_valid_r && step_go;
  assign in_stall  = char_valid_r && !step_go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_valid_r <= 1'b0;
    end else if (!in_stall) begin
      char_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      char_r <= in_char_code;
    end
  end

  // parse state and update
  ipv4p_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (step_fire),
    .cls    (cls),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_fire && cls.is_nul) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && cls.is_nul) begin
      out_ok_r      <= result.ok;
      out_address_r <= result.address;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_ok      = out_ok_r;
  assign out_address = out_address_r;

  // checks
  `IPV4P_ASSERT_IMPLY(a_nul_no_overwrite, step_fire && cls.is_nul, !(out_valid_r && out_stall))
  `IPV4P_ASSERT_NEXT(a_nul_gives_result, step_fire && cls.is_nul, out_valid_r)
  `IPV4P_ASSERT_IMPLY(a_fail_all_ones, out_valid_r && !out_ok_r, out_address_r == ADDR_FAIL)
  `IPV4P_ASSERT_IMPLY(a_stall_only_nul, in_stall, char_valid_r && cls.is_nul)

endmodule
